@@ sv/aip_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aip_pkg
// Shared codes and the character decoder for the ASCII integer parser.
// ----------------------------------------------------------------------------
package aip_pkg;

    // Parse modes
    localparam logic [1:0] MODE_SDEC = 2'd0;
    localparam logic [1:0] MODE_UDEC = 2'd1;
    localparam logic [1:0] MODE_HEX  = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_NO_DIGIT = 2'd0;
    localparam logic [1:0] ST_SUCCESS  = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    // Configuration register indexes
    localparam logic CFG_MODE        = 1'b0;
    localparam logic CFG_DIGIT_LIMIT = 1'b1;

    // Characters and limits
    localparam logic [7:0] CH_MINUS    = 8'h2D;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_NINE     = 8'h39;
    localparam logic [7:0] CH_LOWER_A  = 8'h61;
    localparam logic [7:0] CH_LOWER_F  = 8'h66;
    localparam logic [7:0] CH_UPPER_A  = 8'h41;
    localparam logic [7:0] CH_UPPER_F  = 8'h46;
    localparam logic [7:0] DIGITS_UNLIMITED = 8'hFF;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } digit_t;

    // Decode one character in radix 10 or 16
    function automatic digit_t digit_of(input logic [7:0] c, input logic hex);
        digit_t d;
        logic [7:0] t;
        d = '0;
        t = '0;
        if (c >= CH_ZERO && c <= CH_NINE)
        begin
            t     = c - CH_ZERO;
            d.ok  = 1'b1;
            d.val = t[3:0];
        end
        else if (hex && c >= CH_LOWER_A && c <= CH_LOWER_F)
        begin
            t     = c - CH_LOWER_A + 8'd10;
            d.ok  = 1'b1;
            d.val = t[3:0];
        end
        else if (hex && c >= CH_UPPER_A && c <= CH_UPPER_F)
        begin
            t     = c - CH_UPPER_A + 8'd10;
            d.ok  = 1'b1;
            d.val = t[3:0];
        end
        return d;
    endfunction

endpackage

@@ sv/ascii_integer_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii_integer_parser
// Streaming character-to-integer converter with overflow detection.
//
//   port group   direction   handshake            payload
//   in           sink        in_valid/in_stall    ch, start_req
//   out          source      out_valid/out_stall  done_res, status, value,
//                                                 consumed, took_char
//   cfg          sink        cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One item per cycle sustained while out_stall is low; an accepted item
// goes through the input register, then the result register. The digit step
// (shift-add by the radix, add digit, compare against the bound) sits
// between those two registers. Reset clears the conversion state and loads
// mode 0 and an unlimited digit count. A stall on the output holds the
// result register and backs up into the input register.
// ----------------------------------------------------------------------------
module ascii_integer_parser #(
    parameter int WORD_BITS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    // input items
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  ch,
    input  logic        start_req,
    // result items
    output logic        out_valid,
    input  logic        out_stall,
    output logic        done_res,
    output logic [1:0]  status,
    output logic [63:0] value,
    output logic [8:0]  consumed,
    output logic        took_char,
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);

    localparam int WIDE_BITS = WORD_BITS + 4;

    // configuration
    logic [1:0] mode_reg;
    logic [7:0] digit_limit_reg;

    // input register
    logic       in_vld_reg;
    logic [7:0] ch_reg;
    logic       start_reg;

    // conversion state
    logic [WORD_BITS-1:0] acc_reg, acc_next;
    logic [7:0]           cnt_reg, cnt_next;
    logic                 neg_reg, neg_next;
    logic                 active_reg, active_next;
    logic                 sign_reg, sign_next;

    // result register
    logic        out_vld_reg;
    logic        done_reg, done_next;
    logic [1:0]  status_reg, status_next;
    logic [63:0] value_reg, value_next;
    logic [8:0]  consumed_reg, consumed_next;
    logic        took_reg, took_next;
    logic        idle_item;

    logic advance;
    logic fire;

    // pipeline flow
    assign advance  = !out_vld_reg || !out_stall;
    assign fire     = in_vld_reg && advance;
    assign in_stall = in_vld_reg && !advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= aip_pkg::MODE_SDEC;
            digit_limit_reg <= aip_pkg::DIGITS_UNLIMITED;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                aip_pkg::CFG_MODE:        mode_reg <= cfg_data[1:0];
                aip_pkg::CFG_DIGIT_LIMIT: digit_limit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (!in_stall)
            in_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall)
        begin
            ch_reg    <= ch;
            start_reg <= start_req;
        end
    end

    // digit step
    logic                 limited, hex, sdec, is_minus;
    logic [WORD_BITS-1:0] cur_acc;
    logic [7:0]           cur_cnt;
    logic                 cur_neg, cur_sign;
    aip_pkg::digit_t      dg;
    logic [WIDE_BITS-1:0] wide, bound;
    logic [WORD_BITS-1:0] emit_v;

    always_comb
    begin
        limited  = (digit_limit_reg != aip_pkg::DIGITS_UNLIMITED);
        sdec     = (mode_reg == aip_pkg::MODE_SDEC);
        hex      = !sdec && (mode_reg != aip_pkg::MODE_UDEC);
        is_minus = (ch_reg == aip_pkg::CH_MINUS);
        dg       = aip_pkg::digit_of(ch_reg, hex);

        // a start item begins from a clean word
        cur_acc  = start_reg ? '0 : acc_reg;
        cur_cnt  = start_reg ? 8'd0 : cnt_reg;
        cur_neg  = start_reg ? 1'b0 : neg_reg;
        cur_sign = start_reg ? 1'b0 : sign_reg;

        // word*radix + digit, compared against the mode bound
        if (hex)
            wide = {cur_acc, 4'b0000} + WIDE_BITS'(dg.val);
        else
            wide = WIDE_BITS'({cur_acc, 3'b000}) + WIDE_BITS'({cur_acc, 1'b0})
                 + WIDE_BITS'(dg.val);
        if (!sdec)
            bound = WIDE_BITS'({WORD_BITS{1'b1}});
        else if (cur_neg)
            bound = WIDE_BITS'({1'b1, {(WORD_BITS-1){1'b0}}});
        else
            bound = WIDE_BITS'({1'b0, {(WORD_BITS-1){1'b1}}});

        acc_next    = cur_acc;
        cnt_next    = cur_cnt;
        neg_next    = cur_neg;
        sign_next   = cur_sign;
        active_next = active_reg;
        done_next   = 1'b0;
        status_next = (cur_cnt != 8'd0) ? aip_pkg::ST_SUCCESS : aip_pkg::ST_NO_DIGIT;
        took_next   = 1'b0;
        idle_item   = 1'b0;

        if (start_reg && sdec && is_minus)
        begin
            // leading minus sign
            neg_next    = 1'b1;
            sign_next   = 1'b1;
            took_next   = 1'b1;
            status_next = aip_pkg::ST_NO_DIGIT;
            done_next   = limited && (digit_limit_reg == 8'd0);
            active_next = !done_next;
        end
        else if (!start_reg && !active_reg)
        begin
            idle_item = 1'b1;
        end
        else if ((limited && cur_cnt >= digit_limit_reg) || !dg.ok)
        begin
            // digit limit reached or non-digit: end unconsumed
            done_next   = 1'b1;
            active_next = 1'b0;
        end
        else if (wide > bound)
        begin
            done_next   = 1'b1;
            active_next = 1'b0;
            status_next = aip_pkg::ST_OVERFLOW;
        end
        else
        begin
            acc_next    = wide[WORD_BITS-1:0];
            cnt_next    = (cur_cnt != 8'hFF) ? cur_cnt + 8'd1 : cur_cnt;
            status_next = aip_pkg::ST_SUCCESS;
            took_next   = 1'b1;
            done_next   = limited && (cnt_next >= digit_limit_reg);
            active_next = !done_next;
        end

        // result value: negated and sign-extended in signed mode
        emit_v = (sdec && neg_next) ? (~acc_next + 1'b1) : acc_next;
        if (sdec)
            value_next = 64'(signed'(emit_v));
        else
            value_next = 64'(emit_v);
        consumed_next = 9'(cnt_next) + 9'(sign_next);

        if (idle_item)
        begin
            done_next     = 1'b0;
            status_next   = aip_pkg::ST_NO_DIGIT;
            value_next    = '0;
            consumed_next = '0;
            took_next     = 1'b0;
        end
    end

    // conversion state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg    <= '0;
            cnt_reg    <= '0;
            neg_reg    <= 1'b0;
            active_reg <= 1'b0;
            sign_reg   <= 1'b0;
        end
        else if (fire)
        begin
            acc_reg    <= acc_next;
            cnt_reg    <= cnt_next;
            neg_reg    <= neg_next;
            active_reg <= active_next;
            sign_reg   <= sign_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (advance)
            out_vld_reg <= in_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            done_reg     <= done_next;
            status_reg   <= status_next;
            value_reg    <= value_next;
            consumed_reg <= consumed_next;
            took_reg     <= took_next;
        end
    end

    assign out_valid = out_vld_reg;
    assign done_res  = done_reg;
    assign status    = status_reg;
    assign value     = value_reg;
    assign consumed  = consumed_reg;
    assign took_char = took_reg;

    // checks
    a_ovf_ends: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == aip_pkg::ST_OVERFLOW |-> done_res && !took_char)
        else $error("overflow result must end the conversion unconsumed");

    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !done_res && !took_char |->
            status == aip_pkg::ST_NO_DIGIT && consumed == 9'd0 && value == 64'd0)
        else $error("idle item result must be all zero");

    a_success_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == aip_pkg::ST_SUCCESS |-> consumed != 9'd0)
        else $error("success without any consumed character");

    a_stall_backs_up: assert property (@(posedge clk) disable iff (!rst_n)
        in_vld_reg && out_vld_reg && out_stall |=> in_vld_reg && $stable(ch_reg))
        else $error("input register lost an item under output stall");

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the streaming ASCII integer parser. A scoreboard
// class tracks the conversion state and configuration, predicts the result of
// every accepted character and compares each returned result field by field.
// Stimulus is a short directed sequence followed by random numbers in every
// mode and digit limit, near the overflow bounds, plus noise characters,
// with random idling on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module testbench;

    localparam int RANDOM_ITEMS = 1150;
    localparam int CYCLE_LIMIT  = 500000;
    localparam logic [1:0] MODE_HEX_ALT = 2'd3;  // unused encoding, acts as hex

    typedef struct packed {
        logic        done;
        logic [1:0]  st;
        logic [63:0] val;
        logic [8:0]  cnt;
        logic        took;
    } parse_result_t;

    // Conversion tracker and store of expected results
    class atoi_scoreboard;
        logic [1:0]    mode;
        logic [7:0]    digit_limit;
        logic [63:0]   accum;
        logic [7:0]    digit_count;
        bit            negative;
        bit            active;
        bit            sign_seen;
        parse_result_t expected_results[$];
        int            errors;
        int            checked;
        int            conversions;
        int            overflows;
        int            saturated;

        function new();
            mode        = aip_pkg::MODE_SDEC;
            digit_limit = aip_pkg::DIGITS_UNLIMITED;
            accum       = '0;
            digit_count = '0;
            negative    = 1'b0;
            active      = 1'b0;
            sign_seen   = 1'b0;
            errors      = 0;
            checked     = 0;
            conversions = 0;
            overflows   = 0;
            saturated   = 0;
        endfunction

        function void apply_config(logic idx, logic [7:0] data);
            if (idx == aip_pkg::CFG_MODE)
                mode = data[1:0];
            else
                digit_limit = data;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // Digit of a character, -1 if not a digit in this radix
        function int char_digit(logic [7:0] c, bit hex);
            if (c >= aip_pkg::CH_ZERO && c <= aip_pkg::CH_NINE)
                return int'(c - aip_pkg::CH_ZERO);
            if (hex && c >= aip_pkg::CH_LOWER_A && c <= aip_pkg::CH_LOWER_F)
                return int'(c - aip_pkg::CH_LOWER_A) + 10;
            if (hex && c >= aip_pkg::CH_UPPER_A && c <= aip_pkg::CH_UPPER_F)
                return int'(c - aip_pkg::CH_UPPER_A) + 10;
            return -1;
        endfunction

        function void add_expected(bit done, logic [1:0] st, bit took);
            parse_result_t r;
            r.done = done;
            r.st   = st;
            r.val  = (mode == aip_pkg::MODE_SDEC && negative) ? -accum : accum;
            r.cnt  = {1'b0, digit_count} + 9'(sign_seen);
            r.took = took;
            if (r.cnt == 9'd256)
                saturated++;
            expected_results.push_back(r);
        endfunction

        // Predict the result of one accepted character
        function void take_char(logic [7:0] c, logic start);
            bit          limited;
            bit          hex;
            logic [63:0] radix;
            logic [63:0] bound;
            logic [63:0] dig;
            logic [1:0]  progress;
            int          dv;
            limited = (digit_limit != aip_pkg::DIGITS_UNLIMITED);
            hex     = (mode >= aip_pkg::MODE_HEX);
            radix   = hex ? 64'd16 : 64'd10;
            if (start)
            begin
                conversions++;
                accum       = '0;
                digit_count = '0;
                negative    = 1'b0;
                sign_seen   = 1'b0;
                active      = 1'b1;
                if (mode == aip_pkg::MODE_SDEC && c == aip_pkg::CH_MINUS)
                begin
                    negative  = 1'b1;
                    sign_seen = 1'b1;
                    if (limited && digit_limit == 8'd0)
                    begin
                        active = 1'b0;
                        add_expected(1'b1, aip_pkg::ST_NO_DIGIT, 1'b1);
                    end
                    else
                        add_expected(1'b0, aip_pkg::ST_NO_DIGIT, 1'b1);
                    return;
                end
            end
            else if (!active)
            begin
                // ignored character: all-zero result
                expected_results.push_back('0);
                return;
            end

            progress = (digit_count != 8'd0) ? aip_pkg::ST_SUCCESS : aip_pkg::ST_NO_DIGIT;
            if (limited && digit_count >= digit_limit)
            begin
                active = 1'b0;
                add_expected(1'b1, progress, 1'b0);
                return;
            end
            dv = char_digit(c, hex);
            if (dv < 0)
            begin
                active = 1'b0;
                add_expected(1'b1, progress, 1'b0);
                return;
            end
            dig = 64'(dv);
            if (mode == aip_pkg::MODE_SDEC)
                bound = negative ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
            else
                bound = '1;
            if (accum > (bound - dig) / radix)
            begin
                active = 1'b0;
                overflows++;
                add_expected(1'b1, aip_pkg::ST_OVERFLOW, 1'b0);
                return;
            end
            accum = accum * radix + dig;
            if (digit_count != 8'hFF)
                digit_count++;
            if (limited && digit_count >= digit_limit)
            begin
                active = 1'b0;
                add_expected(1'b1, aip_pkg::ST_SUCCESS, 1'b1);
            end
            else
                add_expected(1'b0, aip_pkg::ST_SUCCESS, 1'b1);
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, name, want, got);
            end
        endfunction

        function void check_result(parse_result_t got);
            parse_result_t want;
            if (expected_results.size() == 0)
            begin
                errors++;
                $display("%0t: result with nothing expected, expected none, actual value %0h",
                         $time, got.val);
                return;
            end
            want = expected_results.pop_front();
            checked++;
            compare_field("done_res", want.done, got.done);
            compare_field("status", want.st, got.st);
            compare_field("value", want.val, got.val);
            compare_field("consumed", want.cnt, got.cnt);
            compare_field("took_char", want.took, got.took);
        endfunction
    endclass

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic        in_stall;
    logic [7:0]  ch         = 8'd0;
    logic        start_req  = 1'b0;
    logic        out_valid;
    logic        out_stall  = 1'b0;
    logic        done_res;
    logic [1:0]  status;
    logic [63:0] value;
    logic [8:0]  consumed;
    logic        took_char;
    logic        cfg_valid  = 1'b0;
    logic        cfg_ready;
    logic        cfg_index  = 1'b0;
    logic [7:0]  cfg_data   = 8'd0;

    atoi_scoreboard sb;
    bit             steady = 1'b0;       // no idling on either side
    int             hold_off_cycles = 0;
    int             items_sent = 0;
    int             cycle_count = 0;
    logic [1:0]     cur_mode = aip_pkg::MODE_SDEC;

    ascii_integer_parser uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .ch        (ch),
        .start_req (start_req),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .done_res  (done_res),
        .status    (status),
        .value     (value),
        .consumed  (consumed),
        .took_char (took_char),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Monitor: results first, then the new item, then register writes
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.check_result(parse_result_t'({done_res, status, value, consumed, took_char}));
            if (in_valid && !in_stall)
                sb.take_char(ch, start_req);
            if (cfg_valid && cfg_ready)
                sb.apply_config(cfg_index, cfg_data);
        end
    end

    // Result side: random stall per item, or one long hold-off on request
    initial
    begin : result_sink
        int n;
        @(posedge clk);
        forever
        begin
            if (hold_off_cycles > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold_off_cycles) @(posedge clk);
                hold_off_cycles = 0;
            end
            else
            begin
                n = steady ? 0 : $urandom_range(0, 13);
                if (n > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (n) @(posedge clk);
                end
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    // Offer one character after a random gap and wait for acceptance
    task automatic send_char(input logic [7:0] c, input logic s, input bit counted);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        ch        <= c;
        start_req <= s;
        do @(posedge clk); while (in_stall);
        if (counted)
            items_sent++;
    endtask

    // Stop sending and wait until every expected result has come back
    task automatic wait_for_results();
        in_valid <= 1'b0;
        do @(negedge clk); while (sb.pending() != 0);
        @(posedge clk);
    endtask

    task automatic set_register(input logic idx, input logic [7:0] data);
        wait_for_results();
        repeat (3) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == aip_pkg::CFG_MODE)
            cur_mode = data[1:0];
    endtask

    function automatic logic [7:0] rand_digit(bit hexm);
        string hex_chars;
        hex_chars = "0123456789abcdefABCDEF";
        if (hexm)
            return hex_chars[$urandom_range(0, 21)];
        return aip_pkg::CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    // One well-formed number with random content, then either a terminator character or none
    task automatic send_number();
        logic [7:0]  text[$];
        string       digits;
        logic [63:0] lim;
        logic [7:0]  c;
        bit          hexm;
        bit          neg;
        int          len;
        hexm = (cur_mode >= aip_pkg::MODE_HEX);
        neg  = (cur_mode == aip_pkg::MODE_SDEC) ? ($urandom_range(0, 1) == 1)
                                                : ($urandom_range(0, 15) == 0);
        case ($urandom_range(0, 9))
            0, 1, 2, 3:
            begin
                len = $urandom_range(1, 6);
                repeat (len) text.push_back(rand_digit(hexm));
            end
            4, 5, 6, 7:
            begin
                // around the overflow bound of the mode
                if (cur_mode == aip_pkg::MODE_SDEC)
                    lim = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
                else
                    lim = '1;
                case ($urandom_range(0, 3))
                    1: lim = lim - 64'($urandom_range(1, 40));
                    2: if (lim != '1) lim = lim + 64'($urandom_range(1, 40));
                    3: lim = lim / (hexm ? 64'd16 : 64'd10);
                    default: ;
                endcase
                digits = hexm ? $sformatf("%0h", lim) : $sformatf("%0d", lim);
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, 3)) text.push_back(aip_pkg::CH_ZERO);
                for (int i = 0; i < digits.len(); i++)
                    text.push_back(digits[i]);
                if ($urandom_range(0, 1) == 1)
                    text.push_back(rand_digit(hexm));
            end
            default:
            begin
                len = $urandom_range(15, 24);
                repeat (len) text.push_back(rand_digit(hexm));
            end
        endcase

        if (neg)
            send_char(aip_pkg::CH_MINUS, 1'b1, 1'b1);
        foreach (text[i])
        begin
            c = text[i];
            if (c >= aip_pkg::CH_LOWER_A && c <= aip_pkg::CH_LOWER_F
                && $urandom_range(0, 1) == 1)
                c = c - 8'h20;
            send_char(c, (i == 0) && !neg, 1'b1);
        end
        case ($urandom_range(0, 3))
            0: send_char(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            1: ;  // cut off by the next start
            2: send_char(" ", 1'b0, 1'b1);
            default: send_char(aip_pkg::CH_MINUS, 1'b0, 1'b1);
        endcase
    endtask

    initial
    begin : stimulus
        int         phase;
        logic [7:0] limit;
        logic       s;
        sb = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: ignored characters, sign, restart, sign-only end
        send_char(8'hFF, 1'b0, 1'b0);
        send_char(8'h00, 1'b0, 1'b0);
        send_char(aip_pkg::CH_MINUS, 1'b1, 1'b1);
        send_char("7", 1'b0, 1'b1);
        send_char("x", 1'b0, 1'b1);
        send_char(aip_pkg::CH_ZERO, 1'b1, 1'b1);
        send_char("5", 1'b1, 1'b1);
        send_char(8'h00, 1'b0, 1'b1);
        send_char(aip_pkg::CH_MINUS, 1'b1, 1'b1);
        send_char(aip_pkg::CH_MINUS, 1'b0, 1'b1);
        // zero digit limit: sign alone ends it, a digit ends unconsumed
        set_register(aip_pkg::CFG_DIGIT_LIMIT, 8'd0);
        send_char(aip_pkg::CH_MINUS, 1'b1, 1'b1);
        send_char("5", 1'b1, 1'b1);
        // unsigned, two digits at most; minus is a plain non-digit
        set_register(aip_pkg::CFG_MODE, {6'd0, aip_pkg::MODE_UDEC});
        set_register(aip_pkg::CFG_DIGIT_LIMIT, 8'd2);
        send_char(aip_pkg::CH_MINUS, 1'b1, 1'b1);
        send_char("1", 1'b1, 1'b1);
        send_char("2", 1'b0, 1'b1);
        send_char("3", 1'b0, 1'b1);
        // hex in both cases, then the spare mode encoding
        set_register(aip_pkg::CFG_MODE, {6'd0, aip_pkg::MODE_HEX});
        set_register(aip_pkg::CFG_DIGIT_LIMIT, aip_pkg::DIGITS_UNLIMITED);
        send_char("f", 1'b1, 1'b1);
        send_char("A", 1'b0, 1'b1);
        send_char("g", 1'b0, 1'b1);
        set_register(aip_pkg::CFG_MODE, {6'h3F, MODE_HEX_ALT});
        send_char("F", 1'b1, 1'b1);
        send_char("a", 1'b0, 1'b1);
        send_char(aip_pkg::CH_ZERO, 1'b0, 1'b1);
        send_char(8'h80, 1'b0, 1'b1);

        // Random phases, each with its own configuration
        items_sent = 0;
        phase = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            steady = 1'b0;
            if (phase == 0)
            begin
                set_register(aip_pkg::CFG_MODE,
                             {6'($urandom_range(0, 63)), aip_pkg::MODE_SDEC});
                set_register(aip_pkg::CFG_DIGIT_LIMIT, aip_pkg::DIGITS_UNLIMITED);
            end
            else
            begin
                case ($urandom_range(0, 7))
                    0: limit = 8'd0;
                    1: limit = 8'd1;
                    2, 3: limit = aip_pkg::DIGITS_UNLIMITED;
                    4: limit = 8'($urandom_range(2, 20));
                    5: limit = 8'd254;
                    default: limit = 8'($urandom_range(0, 255));
                endcase
                set_register(aip_pkg::CFG_MODE,
                             {6'($urandom_range(0, 63)), 2'($urandom_range(0, 3))});
                set_register(aip_pkg::CFG_DIGIT_LIMIT, limit);
                steady = ($urandom_range(0, 3) == 0);
            end

            if (phase == 1)
            begin
                // long output hold-off while items keep coming
                wait_for_results();
                steady = 1'b1;
                hold_off_cycles = 80;
            end
            if (phase == 0)
            begin
                // leading zeros past the digit counter's saturation
                send_char(aip_pkg::CH_MINUS, 1'b1, 1'b1);
                repeat (262) send_char(aip_pkg::CH_ZERO, 1'b0, 1'b1);
                send_char("1", 1'b0, 1'b1);
                send_char(" ", 1'b0, 1'b1);
            end

            repeat ($urandom_range(12, 24))
            begin
                if (items_sent < RANDOM_ITEMS)
                begin
                    send_number();
                    // noise and broken sequences between numbers
                    if ($urandom_range(0, 4) == 0)
                    begin
                        repeat ($urandom_range(1, 3))
                        begin
                            s = ($urandom_range(0, 3) == 0);
                            send_char(8'($urandom_range(0, 255)), s, s);
                        end
                    end
                end
            end
            phase++;
        end

        wait_for_results();
        repeat (8) @(posedge clk);
        $display("checked %0d results in %0d phases: %0d conversions, %0d overflow endings,",
                 sb.checked, phase, sb.conversions, sb.overflows);
        $display("%0d results at the saturated count, %0d mismatches", sb.saturated, sb.errors);
        if (sb.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
